### sv/lrukv_pkg.sv
// Package for the LRU key/value cache: payload word types, cell command
// struct, controller states and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] put_value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_word_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                    clear;
    logic                    touch;
    logic                    set_value;
    logic                    ins;
    logic                    evict;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lrukv_state_t;

endpackage

`default_nettype wire

### sv/lrukv_cell.sv
// One entry of the LRU key/value cache: key, value, valid bit and recency rank.
// Depends on lrukv_pkg; chained to its neighbours through the free-slot token.
`timescale 1ns / 1ps
`default_nettype none

module lrukv_cell import lrukv_pkg::*; #(
  parameter int RANK_W = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [KEY_W-1:0]        lookup_key,
  input  wire cell_cmd_t               cmd,
  input  wire logic [RANK_W-1:0]       hit_rank,
  input  wire logic [RANK_W-1:0]       evict_rank,
  input  wire logic                    free_in,
  output logic                         free_out,
  output logic                         match,
  output logic [RANK_W-1:0]            rank,
  output logic signed [VAL_W-1:0]      value
);

  logic                    valid_r, valid_nxt;
  logic [RANK_W-1:0]       rank_r, rank_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    match_r;
  logic                    victim, avail, claim;

  // Ranks form a permutation of 0..occupancy-1 over the valid cells, so the
  // least recent cell is the one whose rank equals occupancy minus one.
  assign victim   = cmd.evict & valid_r & (rank_r == evict_rank);
  assign avail    = ~valid_r | victim;
  assign claim    = cmd.ins & free_in & avail;
  assign free_out = free_in & ~avail;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    priority if (cmd.clear) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (cmd.touch) begin
      if (match_r) begin
        rank_nxt = '0;
        if (cmd.set_value) begin
          value_nxt = cmd.value;
        end
      end else if (valid_r && (rank_r < hit_rank)) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end else if (cmd.ins) begin
      if (claim) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        key_nxt   = cmd.key;
        value_nxt = cmd.value;
      end else if (victim) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      // The compare runs every cycle; it is used the cycle after acceptance.
      match_r <= valid_r & (key_r == lookup_key);
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign match = match_r;
  assign rank  = rank_r;
  assign value = value_r;

endmodule

`default_nettype wire

### sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache: controller and
// a row of lrukv_cell entries. Depends on lrukv_pkg and lrukv_cell.
//
// Usage. A request word (action, key, put_value) is taken on in_word at a
// rising edge where start is high and busy is low. In the cycle after that
// edge every cell holds the result of its key compare and busy is high; at
// the end of that cycle all cells update their ranks together and, on a
// put that misses, the cell chosen by the free-slot chain takes a new key.
// A get gives one result word on out_word, marked by out_strobe for exactly
// one cycle; it is registered as the busy cycle ends. A put gives no
// result. The receiver cannot stall, so results are never held. busy is
// low again in the cycle the result is shown, so a new request is taken
// only after the last one's registered key compare and rank update.
// Writing cfg_wdata with cfg_we high sets the capacity and empties the cache
// in the same edge; do it only while idle. Reset empties the cache and sets
// the capacity to 16. A capacity of zero acts as one and one above
// MAX_ENTRIES acts as MAX_ENTRIES.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);

  lrukv_state_t            state_r, state_nxt;
  in_word_t                req_r;
  logic [CAP_W-1:0]        cap_r;
  logic [OCC_W-1:0]        occ_r, occ_nxt, occ_m1;
  logic                    out_strobe_r, out_strobe_nxt;
  out_word_t               out_word_r, out_word_nxt;
  logic                    accept, hit, full;
  logic [31:0]             cap_ext, eff_cap;
  logic [RANK_W-1:0]       hit_rank, evict_rank;
  logic signed [VAL_W-1:0] hit_value;
  cell_cmd_t               cmd;

  logic [MAX_ENTRIES-1:0]  match;
  logic [MAX_ENTRIES:0]    free_chain;
  logic [RANK_W-1:0]       rank  [MAX_ENTRIES];
  logic signed [VAL_W-1:0] value [MAX_ENTRIES];

  assign accept = start & (state_r == ST_IDLE);

  // Keys are unique among valid cells, so at most one match bit is set.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_rank  = hit_rank  | (rank[i]  & {RANK_W{match[i]}});
      hit_value = hit_value | (value[i] & {VAL_W{match[i]}});
    end
  end
  assign hit = |match;

  always_comb begin
    cap_ext = 32'(cap_r);
    if (cap_ext == 32'd0) begin
      eff_cap = 32'd1;
    end else if (cap_ext > 32'(MAX_ENTRIES)) begin
      eff_cap = 32'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full       = 32'(occ_r) >= eff_cap;
  assign occ_m1     = occ_r - OCC_W'(1);
  assign evict_rank = occ_m1[RANK_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    busy           = 1'b0;
    occ_nxt        = occ_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    cmd            = '0;
    cmd.key        = req_r.key;
    cmd.value      = req_r.put_value;
    cmd.clear      = cfg_we;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        busy      = 1'b1;
        state_nxt = ST_IDLE;
        cmd.touch = hit;
        if (req_r.action == ACT_PUT) begin
          cmd.set_value = hit;
          cmd.ins       = ~hit;
          cmd.evict     = ~hit & full;
          if (!hit && !full) begin
            occ_nxt = occ_r + OCC_W'(1);
          end
        end else begin
          out_strobe_nxt          = 1'b1;
          out_word_nxt.hit        = hit;
          out_word_nxt.read_value = hit_value;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      occ_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      req_r <= in_word;
    end
  end

  // The free-slot token enters at cell 0 and is taken by the lowest cell
  // that is empty or is being evicted.
  assign free_chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lrukv_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .lookup_key (in_word.key),
      .cmd        (cmd),
      .hit_rank   (hit_rank),
      .evict_rank (evict_rank),
      .free_in    (free_chain[g]),
      .free_out   (free_chain[g+1]),
      .match      (match[g]),
      .rank       (rank[g]),
      .value      (value[g])
    );
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire
